@@ rtl/fgpe_pkg.sv @@
// ----------------------------------------------------------------------------
// fgpe_pkg
// Shared types, constants and the 5-column ASCII font table for the
// character pixel emitter.
// ----------------------------------------------------------------------------
package fgpe_pkg;

  localparam int unsigned CODE_W         = 8;
  localparam int unsigned COLOR_W        = 16;
  localparam int unsigned ADDR_W         = 22;
  localparam int unsigned SCREEN_W       = 12;
  localparam int unsigned DEF_COORD_BITS = 12;

  localparam int unsigned CELL_ROWS  = 8;
  localparam int unsigned CELL_PITCH = 8;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned ROW_W      = 3;
  localparam int unsigned COL_W      = 3;

  localparam int unsigned FONT_GLYPHS = 95;
  localparam int unsigned GLYPH_IDX_W = 7;
  localparam int unsigned GLYPH_W     = GLYPH_COLS * 8;

  localparam logic [CODE_W-1:0] FIRST_CODE = 8'd32;
  localparam logic [CODE_W-1:0] LAST_CODE  = 8'd126;

  localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 12'd480;
  localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 12'd272;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_e;

  // Column 0 sits in the top byte; bit r of a column byte is row r.
  typedef logic [GLYPH_W-1:0] glyph_t;

  localparam glyph_t FONT_ROM [FONT_GLYPHS] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h1008081008
  };

endpackage

@@ rtl/font_glyph_pixel_emitter_top.sv @@
// ----------------------------------------------------------------------------
// font_glyph_pixel_emitter_top
// Renders one 5x8 ASCII character cell as a run of pixel write transactions.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_stall_o) takes one character transaction
// with its position, colors and italic flag. A character whose cell does not
// fit on the screen is accepted and dropped without any output.
// A visible character produces 40 output transactions (out_valid_o /
// out_stall_i), row by row and column 0 to 4 within a row, each carrying a
// linear pixel address and a color; last_pixel_o marks the fortieth.
// An accepted character waits in the holding stage until the pixel stage is
// free, which then offers its first pixel. One pixel leaves per cycle unless
// the output stalls, set by the single pixel write port. A holding
// stage takes the next character while the current one is still emitted.
// A stall on the output freezes the current pixel; the input channel stalls
// once the holding stage is full. The configuration channel (cfg_valid_i /
// cfg_ready_o) is always ready and must only be used while the block is idle.
// Reset empties both stages and loads a 480 x 272 screen.
// ----------------------------------------------------------------------------
module font_glyph_pixel_emitter_top #(
  parameter int unsigned COORD_BITS = fgpe_pkg::DEF_COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fgpe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fgpe_pkg::SCREEN_W-1:0]       cfg_data_i,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fgpe_pkg::CODE_W-1:0]         char_code_i,
  input  logic signed [COORD_BITS-1:0]        pos_x_i,
  input  logic signed [COORD_BITS-1:0]        pos_y_i,
  input  logic [fgpe_pkg::COLOR_W-1:0]        fore_color_i,
  input  logic [fgpe_pkg::COLOR_W-1:0]        back_color_i,
  input  logic                                italic_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fgpe_pkg::ADDR_W-1:0]         pixel_addr_o,
  output logic [fgpe_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic                                last_pixel_o
);

  localparam int unsigned CMP_W  = ((COORD_BITS > fgpe_pkg::SCREEN_W) ?
                                    COORD_BITS : fgpe_pkg::SCREEN_W + 1) + 1;
  localparam int unsigned PROD_W = COORD_BITS - 1 + fgpe_pkg::SCREEN_W;
  localparam int unsigned ADDR_W = fgpe_pkg::ADDR_W;
  localparam int unsigned COLOR_W = fgpe_pkg::COLOR_W;
  localparam int unsigned ROW_W  = fgpe_pkg::ROW_W;
  localparam int unsigned COL_W  = fgpe_pkg::COL_W;

  logic [fgpe_pkg::SCREEN_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= fgpe_pkg::WIDTH_RESET;
      height_q <= fgpe_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (fgpe_pkg::cfg_reg_e'(cfg_index_i))
        fgpe_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        fgpe_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic signed [CMP_W-1:0] px_s, py_s, lim_x, lim_y;
  logic                    visible;
  logic [PROD_W-1:0]       prod;

  always_comb begin
    px_s    = CMP_W'(pos_x_i);
    py_s    = CMP_W'(pos_y_i);
    lim_x   = $signed(CMP_W'(width_q)) - $signed(CMP_W'(fgpe_pkg::CELL_PITCH + 1));
    lim_y   = $signed(CMP_W'(height_q)) - $signed(CMP_W'(fgpe_pkg::CELL_ROWS));
    visible = !px_s[CMP_W-1] && !py_s[CMP_W-1] && !(px_s > lim_x) && !(py_s > lim_y);
    prod    = PROD_W'(pos_y_i[COORD_BITS-2:0]) * PROD_W'(width_q);
  end

  logic               hold_valid_q, hold_valid_d;
  logic [ADDR_W-1:0]  hold_prod_q, hold_px_q;
  logic [COLOR_W-1:0] hold_fg_q, hold_bg_q;
  logic               hold_italic_q;
  fgpe_pkg::glyph_t   rom_glyph;

  logic               active_q, active_d;
  logic [ADDR_W-1:0]  addr_q, addr_d, step_q, step_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  fgpe_pkg::glyph_t   glyph_q;
  logic [COLOR_W-1:0] fg_q, bg_q;

  logic in_fire, out_fire, last, eng_free, load;
  logic [COL_W-1:0] col_sel;

  assign last     = (row_q == ROW_W'(fgpe_pkg::CELL_ROWS - 1)) &&
                    (col_q == COL_W'(fgpe_pkg::GLYPH_COLS - 1));
  assign out_fire = active_q && !out_stall_i;
  assign eng_free = !active_q || (out_fire && last);
  assign load     = hold_valid_q && eng_free;
  assign in_stall_o = hold_valid_q && !eng_free;
  assign in_fire  = in_valid_i && !in_stall_o;

  fgpe_glyph_rom u_rom (
    .clk_i       (clk_i),
    .rd_en_i     (in_fire),
    .char_code_i (char_code_i),
    .glyph_o     (rom_glyph)
  );

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (in_fire) begin
      hold_valid_d = visible;
    end else if (load) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hold_prod_q   <= ADDR_W'(prod);
      hold_px_q     <= ADDR_W'(pos_x_i[COORD_BITS-2:0]);
      hold_fg_q     <= fore_color_i;
      hold_bg_q     <= back_color_i;
      hold_italic_q <= italic_i;
    end
  end

  always_comb begin
    active_d = active_q;
    addr_d   = addr_q;
    step_d   = step_q;
    row_d    = row_q;
    col_d    = col_q;
    if (load) begin
      active_d = 1'b1;
      addr_d   = hold_prod_q + hold_px_q;
      step_d   = ADDR_W'(width_q) - ADDR_W'(fgpe_pkg::GLYPH_COLS - 1) - ADDR_W'(hold_italic_q);
      row_d    = '0;
      col_d    = '0;
    end else if (out_fire) begin
      if (last) begin
        active_d = 1'b0;
      end else if (col_q == COL_W'(fgpe_pkg::GLYPH_COLS - 1)) begin
        col_d  = '0;
        row_d  = row_q + 1'b1;
        addr_d = addr_q + step_q;
      end else begin
        col_d  = col_q + 1'b1;
        addr_d = addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
    end else begin
      active_q <= active_d;
      row_q    <= row_d;
      col_q    <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    step_q <= step_d;
    if (load) begin
      glyph_q <= rom_glyph;
      fg_q    <= hold_fg_q;
      bg_q    <= hold_bg_q;
    end
  end

  assign col_sel       = COL_W'(fgpe_pkg::GLYPH_COLS - 1) - col_q;
  assign out_valid_o   = active_q;
  assign pixel_addr_o  = addr_q;
  assign pixel_color_o = glyph_q[{col_sel, row_q}] ? fg_q : bg_q;
  assign last_pixel_o  = last;

endmodule

@@ rtl/fgpe_glyph_rom.sv @@
// ----------------------------------------------------------------------------
// fgpe_glyph_rom
// Synchronous font memory: maps a character code to its glyph and returns
// the five column bytes, registered, in the cycle after the read is enabled.
// ----------------------------------------------------------------------------
module fgpe_glyph_rom (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [fgpe_pkg::CODE_W-1:0]    char_code_i,
  output fgpe_pkg::glyph_t               glyph_o
);

  logic [fgpe_pkg::GLYPH_IDX_W-1:0] rd_idx;
  fgpe_pkg::glyph_t                 glyph_q;

  always_comb begin
    if (char_code_i < fgpe_pkg::FIRST_CODE || char_code_i > fgpe_pkg::LAST_CODE) begin
      rd_idx = '0;
    end else begin
      rd_idx = fgpe_pkg::GLYPH_IDX_W'(char_code_i - fgpe_pkg::FIRST_CODE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      glyph_q <= fgpe_pkg::FONT_ROM[rd_idx];
    end
  end

  assign glyph_o = glyph_q;

endmodule

@@ rtl/fgpe_checker.sv @@
// ----------------------------------------------------------------------------
// fgpe_checker
// Port-level checks on the character pixel emitter, bound to the top level.
// ----------------------------------------------------------------------------
module fgpe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [fgpe_pkg::ADDR_W-1:0]   pixel_addr_o,
  input logic [fgpe_pkg::COLOR_W-1:0]  pixel_color_o,
  input logic                          last_pixel_o
);

  // A stalled pixel transaction holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_addr_o) &&
      $stable(pixel_color_o) && $stable(last_pixel_o))
    else $error("stalled pixel transaction changed");

  // A character's pixels come without gaps until the last one.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_pixel_o |=> out_valid_o)
    else $error("pixel run ended before the last pixel");

  // With no pixel pending, the input side is never stalled.
  a_idle_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the pixel stage is empty");

  // Reset empties the pixel stage.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("pixel valid during reset");

endmodule

bind font_glyph_pixel_emitter_top fgpe_checker u_fgpe_checker (.*);

@@ dv/tb_font_glyph_pixel_emitter_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_font_glyph_pixel_emitter_top
// Self-checking bench for the 5x8 character pixel emitter. A driver feeds
// character transactions from a backlog queue, a monitor predicts the forty
// pixel writes of every accepted character that fits on the screen and
// compares each output transaction field by field. The run steps through
// several screen sizes, from 9 x 8, which fits one cell, up to the widest
// 12-bit width, and through phases of sender gaps, receiver stalls and one
// long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_font_glyph_pixel_emitter_top;

  localparam int PRINT_FIRST = 32;
  localparam int PRINT_LAST  = 126;
  localparam int ROWS        = 8;
  localparam int COLS        = 5;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [fgpe_pkg::CODE_W-1:0]   code;
    logic [11:0]                   x;
    logic [11:0]                   y;
    logic [fgpe_pkg::COLOR_W-1:0]  fg;
    logic [fgpe_pkg::COLOR_W-1:0]  bg;
    logic                          italic;
  } char_req_t;

  typedef struct packed {
    logic [fgpe_pkg::ADDR_W-1:0]  addr;
    logic [fgpe_pkg::COLOR_W-1:0] color;
    logic                         last;
  } pixel_wr_t;

  logic [7:0] font_columns [475] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
    8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
    8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
    8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
    8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
    8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
    8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
    8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
    8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
    8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06,
    8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
    8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41,
    8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h3E,8'h41,8'h49,8'h49,8'h7A,
    8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
    8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h0C,8'h02,8'h7F,
    8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
    8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
    8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h38,8'h40,8'h3F,
    8'h63,8'h14,8'h08,8'h14,8'h63, 8'h07,8'h08,8'h70,8'h08,8'h07,
    8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h7F,8'h41,8'h41,8'h00,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7F,8'h00,
    8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
    8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20,
    8'h38,8'h44,8'h44,8'h48,8'h7F, 8'h38,8'h54,8'h54,8'h54,8'h18,
    8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h0C,8'h52,8'h52,8'h52,8'h3E,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00,
    8'h20,8'h40,8'h44,8'h3D,8'h00, 8'h7F,8'h10,8'h28,8'h44,8'h00,
    8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38,
    8'h7C,8'h14,8'h14,8'h14,8'h08, 8'h08,8'h14,8'h14,8'h18,8'h7C,
    8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C,
    8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h3C,8'h40,8'h30,8'h40,8'h3C,
    8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00,
    8'h00,8'h00,8'h7F,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00,
    8'h10,8'h08,8'h08,8'h10,8'h08
  };

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready_o;
  fgpe_pkg::cfg_reg_e            cfg_index = fgpe_pkg::REG_SCREEN_WIDTH;
  logic [fgpe_pkg::SCREEN_W-1:0] cfg_data  = '0;

  logic      in_valid = 1'b0;
  logic      in_stall_o;
  char_req_t cur_char = '0;

  logic                         out_valid_o;
  logic                         out_stall = 1'b0;
  logic [fgpe_pkg::ADDR_W-1:0]  pixel_addr_o;
  logic [fgpe_pkg::COLOR_W-1:0] pixel_color_o;
  logic                         last_pixel_o;

  logic [fgpe_pkg::SCREEN_W-1:0] screen_w = fgpe_pkg::WIDTH_RESET;
  logic [fgpe_pkg::SCREEN_W-1:0] screen_h = fgpe_pkg::HEIGHT_RESET;

  char_req_t char_backlog [$];
  pixel_wr_t pending_pixels [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int pixel_errors  = 0;

  font_glyph_pixel_emitter_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .char_code_i  (cur_char.code),
    .pos_x_i      (cur_char.x),
    .pos_y_i      (cur_char.y),
    .fore_color_i (cur_char.fg),
    .back_color_i (cur_char.bg),
    .italic_i     (cur_char.italic),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .pixel_addr_o (pixel_addr_o),
    .pixel_color_o(pixel_color_o),
    .last_pixel_o (last_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("font_glyph_pixel_emitter_top regression: fail");
    $finish;
  end

  function automatic void render_glyph_pixels(char_req_t c);
    int        px;
    int        py;
    int        w;
    int        h;
    int        code;
    int        a;
    pixel_wr_t p;
    px = $signed(c.x);
    py = $signed(c.y);
    w  = int'(screen_w);
    h  = int'(screen_h);
    if (px < 0 || py < 0 || px > w - 9 || py > h - ROWS) return;
    code = int'(c.code);
    if (code < PRINT_FIRST || code > PRINT_LAST) code = PRINT_FIRST;
    for (int row = 0; row < ROWS; row++) begin
      for (int col = 0; col < COLS; col++) begin
        a = (py + row) * w + px + col - (c.italic ? row : 0);
        p.addr  = a[fgpe_pkg::ADDR_W-1:0];
        p.color = font_columns[(code - PRINT_FIRST) * COLS + col][row] ? c.fg : c.bg;
        p.last  = (row == ROWS - 1) && (col == COLS - 1);
        pending_pixels.push_back(p);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall_o) begin
      if (char_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_char <= char_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    pixel_wr_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) render_glyph_pixels(cur_char);
      if (out_valid_o && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel write, expected none, actual addr %h color %h last %b",
                   $time, pixel_addr_o, pixel_color_o, last_pixel_o);
          pixel_errors++;
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_addr_o !== want.addr) begin
            $display("%0t: pixel_addr expected %h actual %h", $time, want.addr, pixel_addr_o);
            pixel_errors++;
          end
          if (pixel_color_o !== want.color) begin
            $display("%0t: pixel_color expected %h actual %h", $time, want.color,
                     pixel_color_o);
            pixel_errors++;
          end
          if (last_pixel_o !== want.last) begin
            $display("%0t: last_pixel expected %b actual %b", $time, want.last, last_pixel_o);
            pixel_errors++;
          end
        end
      end
    end
  end

  task automatic queue_char(int code, int x, int y, int fg, int bg, int it);
    char_req_t c;
    c.code   = code[fgpe_pkg::CODE_W-1:0];
    c.x      = x[11:0];
    c.y      = y[11:0];
    c.fg     = fg[fgpe_pkg::COLOR_W-1:0];
    c.bg     = bg[fgpe_pkg::COLOR_W-1:0];
    c.italic = it[0];
    char_backlog.push_back(c);
  endtask

  task automatic queue_random_chars(int count);
    int xmax;
    int ymax;
    int pick;
    xmax = int'(screen_w) - 9;
    ymax = int'(screen_h) - ROWS;
    if (xmax > 2047) xmax = 2047;
    if (ymax > 2047) ymax = 2047;
    for (int i = 0; i < count; i++) begin
      char_req_t c;
      c.code = ($urandom_range(3) == 0) ?
               fgpe_pkg::CODE_W'($urandom_range(255)) :
               fgpe_pkg::CODE_W'($urandom_range(PRINT_LAST, PRINT_FIRST));
      pick = $urandom_range(9);
      if (xmax < 0 || pick == 0) c.x = 12'($urandom);
      else if (pick == 1) c.x = 12'(xmax);
      else c.x = 12'($urandom_range(xmax));
      pick = $urandom_range(9);
      if (ymax < 0 || pick == 0) c.y = 12'($urandom);
      else if (pick == 1) c.y = 12'(ymax);
      else c.y = 12'($urandom_range(ymax));
      c.fg     = fgpe_pkg::COLOR_W'($urandom);
      c.bg     = fgpe_pkg::COLOR_W'($urandom);
      c.italic = 1'($urandom_range(1));
      char_backlog.push_back(c);
    end
  endtask

  task automatic drain;
    do @(posedge clk_i);
    while (char_backlog.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_screen(int w, int h);
    cfg_valid <= 1'b1;
    cfg_index <= fgpe_pkg::REG_SCREEN_WIDTH;
    cfg_data  <= w[fgpe_pkg::SCREEN_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    screen_w = w[fgpe_pkg::SCREEN_W-1:0];
    cfg_index <= fgpe_pkg::REG_SCREEN_HEIGHT;
    cfg_data  <= h[fgpe_pkg::SCREEN_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    screen_h = h[fgpe_pkg::SCREEN_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset screen of 480 x 272: font corners, clip edges and code ranges.
    set_idling(0, 0);
    queue_char(65, 0, 0, 'hFFFF, 'h0000, 0);
    queue_char(65, 0, 0, 'h0000, 'hFFFF, 1);
    queue_char(0, 10, 10, 'hF800, 'h07E0, 0);
    queue_char(31, 20, 20, 'h001F, 'hAAAA, 1);
    queue_char(32, 30, 30, 'h5555, 'h1234, 0);
    queue_char(126, 471, 264, 'hFFFF, 'h0000, 1);
    queue_char(127, 100, 100, 'hABCD, 'h4321, 0);
    queue_char(255, 200, 100, 'h0F0F, 'hF0F0, 1);
    queue_char(48, 472, 0, 'hFFFF, 'h0000, 0);
    queue_char(48, 0, 265, 'hFFFF, 'h0000, 0);
    queue_char(64, -1, 0, 'hFFFF, 'h0000, 0);
    queue_char(64, 0, -1, 'hFFFF, 'h0000, 1);
    queue_char(64, -2048, -2048, 'hFFFF, 'h0000, 0);
    queue_char(64, 2047, 2047, 'hFFFF, 'h0000, 1);
    queue_char(35, 471, 0, 'h8001, 'h7FFE, 1);
    queue_char(87, 0, 264, 'h7FFE, 'h8001, 0);
    queue_char(126, 1, 1, 'hC3C3, 'h3C3C, 1);
    queue_random_chars(30);
    drain();

    write_screen(16, 16);
    set_idling(46, 0);
    queue_char(77, 7, 8, 'hFFFF, 'h0000, 1);
    queue_char(77, 8, 8, 'hFFFF, 'h0000, 0);
    queue_char(77, 7, 9, 'hFFFF, 'h0000, 0);
    queue_random_chars(30);
    drain();

    write_screen(4095, 4095);
    set_idling(0, 46);
    queue_char(38, 2047, 2047, 'h1357, 'h2468, 1);
    queue_char(123, 2047, 0, 'h9ABC, 'hDEF0, 0);
    queue_random_chars(40);
    drain();

    // A width or height of 2048 fits in the 12-bit register without wrapping.
    write_screen(2048, 2048);
    set_idling(36, 36);
    queue_char(65, 0, 0, 'hFFFF, 'h0000, 0);
    queue_random_chars(10);
    drain();

    write_screen(9, 8);
    queue_char(72, 0, 0, 'hFFFF, 'h0000, 1);
    queue_char(72, 1, 0, 'hFFFF, 'h0000, 0);
    queue_char(72, 0, 1, 'hFFFF, 'h0000, 0);
    queue_random_chars(5);
    drain();

    write_screen(640, 480);
    set_idling(0, 0);
    queue_random_chars(60);
    hold_requests = hold_requests + 1;
    drain();

    write_screen($urandom_range(2047, 16), $urandom_range(2047, 16));
    set_idling(36, 36);
    queue_random_chars(60);
    drain();

    if (pixel_errors == 0 && pending_pixels.size() == 0) begin
      $display("font_glyph_pixel_emitter_top regression: pass");
    end else begin
      $display("font_glyph_pixel_emitter_top regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fgpe_pkg.sv
rtl/fgpe_glyph_rom.sv
rtl/font_glyph_pixel_emitter_top.sv
rtl/fgpe_checker.sv
dv/tb_font_glyph_pixel_emitter_top.sv
